@@ rtl/b64sd_pkg.sv @@
// ----------------------------------------------------------------------------
// b64sd_pkg
// shared types, character codes and the symbol decode for the base64
// stream decoder
// ----------------------------------------------------------------------------
package b64sd_pkg;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PAD   = 8'h3d;  // '='
  localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [7:0] CH_SLASH = 8'h2f;  // '/'
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  // symbol value offsets
  localparam logic [5:0] OFS_LOWER = 6'd26;
  localparam logic [5:0] OFS_DIGIT = 6'd52;
  localparam logic [5:0] VAL_PLUS  = 6'd62;
  localparam logic [5:0] VAL_SLASH = 6'd63;

  // width of the reported byte total
  localparam int TOTAL_W = 16;

  // slots in the queue between front and back
  localparam int QDEPTH = 2;

  // decoded symbol: ok flag and 6-bit value
  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sym_t;

  // work handed from front to back: up to three kept bytes of one item
  typedef struct packed {
    logic [2:0][7:0]      bytes;   // kept bytes in output order, slot 0 first
    logic [1:0]           nk;      // number of kept bytes
    logic                 eos;     // item closes the string
    logic [TOTAL_W-1:0]   base;    // byte count before this item
  } job_t;

  function automatic sym_t sym_decode(input logic [7:0] c);
    sym_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      s.val = 6'(c - CH_UP_A);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      s.val = 6'(c - CH_LO_A) + OFS_LOWER;
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      s.val = 6'(c - CH_DIG_0) + OFS_DIGIT;
    end else if (c == CH_PLUS) begin
      s.val = VAL_PLUS;
    end else if (c == CH_SLASH) begin
      s.val = VAL_SLASH;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/b64sd_if.sv @@
// ----------------------------------------------------------------------------
// b64sd channel interfaces
// valid/ready channels for encoded characters in and decoded results out
// ----------------------------------------------------------------------------
interface b64sd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  character;
  logic        end_of_string;
  logic [15:0] output_limit;

  modport source (output valid, output character, output end_of_string,
                  output output_limit, input ready);
  modport sink   (input valid, input character, input end_of_string,
                  input output_limit, output ready);
endinterface

interface b64sd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        run_last;
  logic        string_done;
  logic [15:0] total_written;

  modport source (output valid, output data_byte, output byte_valid,
                  output run_last, output string_done, output total_written,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input run_last, input string_done, input total_written,
                  output ready);
endinterface

@@ rtl/b64sd_front.sv @@
// ----------------------------------------------------------------------------
// b64sd_front
// classifies characters, collects groups of four symbols, applies the byte
// limit and hands one job per producing item to the queue
// ----------------------------------------------------------------------------
module b64sd_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          character,
  input  logic                end_of_string,
  input  logic [15:0]         output_limit,
  output logic                push,
  output b64sd_pkg::job_t     job
);

  localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({COUNT_BITS{1'b1}});

  logic [1:0]            fill_r, fill_nxt;
  logic [COUNT_BITS-1:0] bw_r, bw_nxt;
  logic [2:0][5:0]       sym_r;
  logic                  pad2_r;

  b64sd_pkg::sym_t       dec;
  logic                  is_ws, is_pad, take, full;
  logic [5:0]            cur_sym;
  logic [7:0]            b0, b1, b2;
  logic [1:0]            nc, nk;
  logic [2:0]            room;
  logic [CMP_W-1:0]      lim_e, bw_e;

  // classify the character
  always_comb begin
    dec     = b64sd_pkg::sym_decode(character);
    is_ws   = (character == b64sd_pkg::CH_CR) || (character == b64sd_pkg::CH_LF) ||
              (character == b64sd_pkg::CH_SP) || (character == b64sd_pkg::CH_TAB);
    is_pad  = (character == b64sd_pkg::CH_PAD);
    take    = !is_ws && (dec.ok || is_pad);
    cur_sym = is_pad ? 6'd0 : dec.val;
    full    = take && (fill_r == 2'd3);
  end

  // assemble the three bytes of a full group and the candidate count
  always_comb begin
    b0 = {sym_r[0], sym_r[1][5:4]};
    b1 = {sym_r[1][3:0], sym_r[2][5:2]};
    b2 = {sym_r[2][1:0], cur_sym};
    if (full) begin
      nc = 2'd1 + 2'(!pad2_r) + 2'(!is_pad);
    end else begin
      nc = 2'd0;
    end
  end

  // room left under the limit and under the counter ceiling
  always_comb begin
    lim_e = CMP_W'(output_limit);
    bw_e  = CMP_W'(bw_r);
    for (int j = 0; j < 3; j++) begin
      room[j] = ((bw_e + CMP_W'(j)) < lim_e) && ((bw_e + CMP_W'(j)) < CNT_MAX);
    end
    nk = 2'((nc >= 2'd1) && room[0]) + 2'((nc >= 2'd2) && room[1]) +
         2'((nc == 2'd3) && room[2]);
  end

  // job to the queue
  always_comb begin
    job.bytes[0] = b0;
    job.bytes[1] = pad2_r ? b2 : b1;
    job.bytes[2] = b2;
    job.nk       = nk;
    job.eos      = end_of_string;
    job.base     = b64sd_pkg::TOTAL_W'(bw_r);
    push         = accept && ((nk != 2'd0) || end_of_string);
  end

  // next group fill and byte count
  always_comb begin
    fill_nxt = fill_r;
    bw_nxt   = bw_r;
    if (accept) begin
      if (end_of_string) begin
        fill_nxt = 2'd0;
        bw_nxt   = '0;
      end else begin
        if (take) begin
          fill_nxt = fill_r + 2'd1;
        end
        bw_nxt = bw_r + COUNT_BITS'(nk);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      bw_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      bw_r   <= bw_nxt;
    end
  end

  // group symbol storage
  always_ff @(posedge clk) begin
    if (accept && take && (fill_r != 2'd3)) begin
      sym_r[fill_r] <= cur_sym;
      if (fill_r == 2'd2) begin
        pad2_r <= is_pad;
      end
    end
  end

endmodule

@@ rtl/b64sd_queue.sv @@
// ----------------------------------------------------------------------------
// b64sd_queue
// short fifo of jobs between the front and the back
// ----------------------------------------------------------------------------
module b64sd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64sd_pkg::job_t  push_job,
  output logic             not_full,
  input  logic             pop,
  output logic             head_valid,
  output b64sd_pkg::job_t  head_job
);

  localparam int PW = $clog2(b64sd_pkg::QDEPTH);
  localparam int CW = $clog2(b64sd_pkg::QDEPTH + 1);

  b64sd_pkg::job_t mem [b64sd_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  // occupancy and pointers
  always_comb begin
    not_full   = (cnt_r != CW'(b64sd_pkg::QDEPTH));
    head_valid = (cnt_r != '0);
    head_job   = mem[rd_ptr_r];
    do_push    = push && not_full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(b64sd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(b64sd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/b64sd_back.sv @@
// ----------------------------------------------------------------------------
// b64sd_back
// walks the head job one result at a time into the output register
// ----------------------------------------------------------------------------
module b64sd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  b64sd_pkg::job_t  head_job,
  output logic             pop,
  b64sd_out_if.source      out_chan
);

  logic [1:0]  idx_r, idx_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  data_r;
  logic        bvalid_r, last_r, done_r;
  logic [15:0] total_r;
  logic        load, is_last, has_byte;

  // pick the next result from the head job
  always_comb begin
    has_byte = (head_job.nk != 2'd0);
    is_last  = !has_byte || (idx_r == head_job.nk - 2'd1);
    load     = head_valid && (!ov_r || out_chan.ready);
    pop      = load && is_last;
    idx_nxt  = idx_r;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (load) begin
      idx_nxt = idx_r + 2'd1;
    end
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_chan.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      ov_r  <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= has_byte ? head_job.bytes[idx_r] : 8'd0;
      bvalid_r <= has_byte;
      last_r   <= is_last;
      done_r   <= is_last && head_job.eos;
      total_r  <= has_byte ? head_job.base + 16'(idx_r) + 16'd1 : head_job.base;
    end
  end

  assign out_chan.valid         = ov_r;
  assign out_chan.data_byte     = data_r;
  assign out_chan.byte_valid    = bvalid_r;
  assign out_chan.run_last      = last_r;
  assign out_chan.string_done   = done_r;
  assign out_chan.total_written = total_r;

endmodule

@@ rtl/base64_stream_decoder_unit.sv @@
// an accepted character's results pass the job queue, then the output register
// throughput: one character per cycle in while the queue has room; one result beat
//   per cycle out while the receiver is ready; four symbols give up to three beats
// the two-slot job queue lets the input run on while the output drains
// reset (synchronous, active low) empties the queue and output and clears the count
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// streaming base64 decoder: character in, decoded bytes and string totals out
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  b64sd_in_if.sink      in_chan,
  b64sd_out_if.source   out_chan
);

  logic             accept, push, not_full, pop, head_valid;
  b64sd_pkg::job_t  job, head_job;

  // input beat handshake
  assign in_chan.ready = not_full;
  assign accept        = in_chan.valid && not_full;

  b64sd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .character     (in_chan.character),
    .end_of_string (in_chan.end_of_string),
    .output_limit  (in_chan.output_limit),
    .push          (push),
    .job           (job)
  );

  b64sd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (job),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64sd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base64_stream_decoder_unit. Characters go in as
// single beats. A local decoder model predicts every result beat: decoded
// bytes, the output limit, the count ceiling and the closing beat. Each
// result beat is checked against the oldest prediction. Sender and receiver
// idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam logic [15:0] COUNT_FULL     = 16'hffff;

  // one result beat as the block should present it
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        run_last;
    logic        string_done;
    logic [15:0] total_written;
  } dec_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  b64sd_in_if  in_if ();
  b64sd_out_if out_if ();

  base64_stream_decoder_unit #(.COUNT_BITS(16)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // decoder model state
  logic [5:0]  grp_val [4] = '{default: '0};
  logic        grp_pad [4] = '{default: 1'b0};
  logic [1:0]  grp_fill    = '0;
  logic [15:0] byte_count  = '0;

  dec_beat_t   decoded_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned chars_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  // model of one character: appends the beats it causes
  function automatic void decode_char(input logic [7:0] ch, input logic eos,
                                      input logic [15:0] lim);
    dec_beat_t  run[$];
    dec_beat_t  tail;
    logic [5:0] val;
    logic       is_sym;
    logic [1:0] slot;
    logic [7:0] trio [3];
    logic [2:0] keep;
    is_sym = 1'b1;
    val    = '0;
    // blanks and anything outside the alphabet fall through as skipped
    if (ch >= b64sd_pkg::CH_UP_A && ch <= b64sd_pkg::CH_UP_Z) begin
      val = 6'(ch - b64sd_pkg::CH_UP_A);
    end else if (ch >= b64sd_pkg::CH_LO_A && ch <= b64sd_pkg::CH_LO_Z) begin
      val = 6'(ch - b64sd_pkg::CH_LO_A) + b64sd_pkg::OFS_LOWER;
    end else if (ch >= b64sd_pkg::CH_DIG_0 && ch <= b64sd_pkg::CH_DIG_9) begin
      val = 6'(ch - b64sd_pkg::CH_DIG_0) + b64sd_pkg::OFS_DIGIT;
    end else if (ch == b64sd_pkg::CH_PLUS) begin
      val = b64sd_pkg::VAL_PLUS;
    end else if (ch == b64sd_pkg::CH_SLASH) begin
      val = b64sd_pkg::VAL_SLASH;
    end else if (ch != b64sd_pkg::CH_PAD) begin
      is_sym = 1'b0;
    end

    if (is_sym) begin
      slot          = grp_fill;
      grp_val[slot] = val;
      grp_pad[slot] = (ch == b64sd_pkg::CH_PAD);
      if (slot == 2'd3) begin
        trio[0] = {grp_val[0], grp_val[1][5:4]};
        trio[1] = {grp_val[1][3:0], grp_val[2][5:2]};
        trio[2] = {grp_val[2][1:0], grp_val[3]};
        keep    = {!grp_pad[3], !grp_pad[2], 1'b1};
        for (int i = 0; i < 3; i++) begin
          // limit and count ceiling both drop the byte silently
          if (keep[i] && byte_count < lim && byte_count != COUNT_FULL) begin
            byte_count++;
            run.push_back('{data_byte: trio[i], byte_valid: 1'b1, run_last: 1'b0,
                            string_done: 1'b0, total_written: byte_count});
          end
        end
        grp_fill = '0;
      end else begin
        grp_fill = slot + 2'd1;
      end
    end

    // end mark: close the string, drop any partial group
    if (eos) begin
      if (run.size() == 0) begin
        run.push_back('{data_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0,
                        string_done: 1'b1, total_written: byte_count});
      end else begin
        tail = run.pop_back();
        tail.string_done = 1'b1;
        run.push_back(tail);
      end
      grp_val    = '{default: '0};
      grp_pad    = '{default: 1'b0};
      grp_fill   = '0;
      byte_count = '0;
    end

    if (run.size() != 0) begin
      tail = run.pop_back();
      tail.run_last = 1'b1;
      run.push_back(tail);
    end
    foreach (run[i]) decoded_q.push_back(run[i]);
  endfunction

  function automatic logic [7:0] b64_char(input int unsigned idx);
    if (idx < b64sd_pkg::OFS_LOWER) return b64sd_pkg::CH_UP_A + 8'(idx);
    if (idx < b64sd_pkg::OFS_DIGIT)
      return b64sd_pkg::CH_LO_A + 8'(idx - b64sd_pkg::OFS_LOWER);
    if (idx < b64sd_pkg::VAL_PLUS)
      return b64sd_pkg::CH_DIG_0 + 8'(idx - b64sd_pkg::OFS_DIGIT);
    if (idx == b64sd_pkg::VAL_PLUS) return b64sd_pkg::CH_PLUS;
    return b64sd_pkg::CH_SLASH;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return b64sd_pkg::CH_CR;
      1: return b64sd_pkg::CH_LF;
      2: return b64sd_pkg::CH_SP;
      default: return b64sd_pkg::CH_TAB;
    endcase
  endfunction

  // offer one character beat, wait for it to be taken
  task automatic send_char(input logic [7:0] ch, input logic eos, input logic [15:0] lim);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.character     <= ch;
    in_if.end_of_string <= eos;
    in_if.output_limit  <= lim;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    decode_char(ch, eos, lim);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic [15:0] lim, input logic eos_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eos_last && (i == s.len() - 1), lim);
  endtask

  // alphabet extremes, pads, skipped bytes, limits 0 and max, closing cases
  task automatic test_directed_cases();
    send_text("//+/", 16'hffff, 1'b1);
    // blanks and stray bytes inside a group, limit cuts the third byte
    send_char(b64sd_pkg::CH_UP_A, 1'b0, 16'd2);
    send_char(b64sd_pkg::CH_SP,   1'b0, 16'd2);
    send_char(b64sd_pkg::CH_UP_A, 1'b0, 16'd2);
    send_char(8'h00,              1'b0, 16'd2);
    send_char(b64sd_pkg::CH_UP_A, 1'b0, 16'd2);
    send_char(b64sd_pkg::CH_UP_A, 1'b1, 16'd2);
    send_text("TQ==", 16'd5, 1'b1);
    // partial group thrown away by a skipped end character
    send_text("=9a", 16'd7, 1'b0);
    send_char(8'hff, 1'b1, 16'd7);
    // limit zero suppresses everything, close on a tab
    send_text("Zz0=", 16'd0, 1'b0);
    send_char(8'h80,               1'b0, 16'd0);
    send_char(b64sd_pkg::CH_TAB,   1'b1, 16'd0);
  endtask

  // mostly well-formed strings with random content, some noise and breakage
  task automatic test_random_strings(input int unsigned n_chars);
    int unsigned stop_at;
    int unsigned groups;
    int unsigned pads;
    int unsigned tail;
    int unsigned r;
    logic [15:0] lim;
    logic [7:0]  ch;
    logic        eos;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      case ($urandom_range(9))
        0: lim = 16'($urandom);
        1: lim = 16'hffff;
        2: lim = '0;
        default: lim = 16'($urandom_range(14));
      endcase
      if ($urandom_range(9) == 0) begin
        // raw noise burst, any byte, end marks now and then
        repeat (6) send_char(8'($urandom), $urandom_range(3) == 0, 16'($urandom));
      end else begin
        groups = $urandom_range(1, 5);
        pads   = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
        tail   = $urandom_range(5);
        for (int g = 0; g < groups; g++) begin
          for (int k = 0; k < 4; k++) begin
            r = $urandom_range(19);
            if (r == 0) send_char(blank_char(), 1'b0, lim);
            else if (r == 1) send_char(8'($urandom), 1'b0, lim);
            if ($urandom_range(15) == 0) lim = 16'($urandom_range(14));
            if (g == groups - 1 && k >= 4 - pads) ch = b64sd_pkg::CH_PAD;
            else ch = b64_char($urandom_range(63));
            eos = (tail > 2) && (g == groups - 1) && (k == 3);
            send_char(ch, eos, lim);
          end
        end
        // other ways to close: trailing blank, partial group, stray byte
        case (tail)
          0: send_char(blank_char(), 1'b1, lim);
          1: begin
            r = $urandom_range(1, 3);
            repeat (r - 1) send_char(b64_char($urandom_range(63)), 1'b0, lim);
            send_char(b64_char($urandom_range(63)), 1'b1, lim);
          end
          2: send_char(8'($urandom), 1'b1, lim);
          default: ;
        endcase
      end
    end
  endtask

  // receiver holds off while full groups keep coming, input must stall
  task automatic test_output_stall();
    hold_req = 300;
    for (int i = 0; i < 20; i++)
      send_char((i % 4 == 3) ? b64sd_pkg::CH_PLUS : b64sd_pkg::CH_SLASH, i == 19, 16'hffff);
  endtask

  // receiver: random stalls, plus the long hold-off when asked
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_beat
    dec_beat_t got;
    dec_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{data_byte: out_if.data_byte, byte_valid: out_if.byte_valid,
              run_last: out_if.run_last, string_done: out_if.string_done,
              total_written: out_if.total_written};
      if (decoded_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: byte %h valid %b last %b done %b total %0d",
                   got.data_byte, got.byte_valid, got.run_last, got.string_done,
                   got.total_written);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: byte %h/%h valid %b/%b last %b/%b done %b/%b ",
                      "total %0d/%0d (expected/actual)"},
                     want.data_byte, got.data_byte, want.byte_valid, got.byte_valid,
                     want.run_last, got.run_last, want.string_done, got.string_done,
                     want.total_written, got.total_written);
        end
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.character     = '0;
    in_if.end_of_string = 1'b0;
    in_if.output_limit  = '0;
    rst_n               = 1'b0;
    send_idle_pct       = 16;
    recv_idle_pct       = 77;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_strings(30);
    send_idle_pct = 77;
    recv_idle_pct = 16;
    test_random_strings(30);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_strings(30);
    test_output_stall();
    in_if.valid <= 1'b0;

    // drain, then watch for any stray beat
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
